[rtl/joystick_axis_boost_ramp_macros.svh]
// Assertion macros shared by the joystick axis boost ramp RTL.
`ifndef JOYSTICK_AXIS_BOOST_RAMP_MACROS_SVH
`define JOYSTICK_AXIS_BOOST_RAMP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JABR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JABR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/jabr_pkg.sv]
// Types and constants shared by the joystick axis boost ramp modules.
package jabr_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MUL_W      = 18;
    localparam int unsigned PROD_W     = 2 * MUL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd5;

    localparam logic [14:0]        RST_THRESHOLD  = 15'd4915;
    localparam logic [15:0]        RST_ACCEL_RATE = 16'd5033;
    localparam logic [15:0]        RST_DECEL_RATE = 16'd33554;
    localparam logic [14:0]        RST_LIMIT      = 15'd16384;
    localparam logic [15:0]        RST_TIMEOUT    = 16'd500;
    localparam logic signed [15:0] RST_GAIN       = 16'sd819;

    typedef struct packed {
        logic [14:0]        threshold;
        logic [15:0]        accel_rate;
        logic [15:0]        decel_rate;
        logic [14:0]        limit;
        logic [15:0]        timeout_ticks;
        logic signed [15:0] gain;
    } cfg_t;

    typedef struct packed {
        logic                    load;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RAMP,
        ST_BOOST,
        ST_DRIVE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RAMP_POS,
        RAMP_NEG,
        RAMP_DECAY
    } ramp_t;

endpackage

[rtl/jabr_cfg.sv]
// Configuration register file for the joystick axis boost ramp.
module jabr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [jabr_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [jabr_pkg::CFG_DATA_W-1:0]    wr_data,
    output jabr_pkg::cfg_t                     cfg
);

    jabr_pkg::cfg_t cfg_reg;
    jabr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                jabr_pkg::CFG_THRESHOLD:  cfg_next.threshold     = wr_data[14:0];
                jabr_pkg::CFG_ACCEL_RATE: cfg_next.accel_rate    = wr_data;
                jabr_pkg::CFG_DECEL_RATE: cfg_next.decel_rate    = wr_data;
                jabr_pkg::CFG_LIMIT:      cfg_next.limit         = wr_data[14:0];
                jabr_pkg::CFG_TIMEOUT:    cfg_next.timeout_ticks = wr_data;
                jabr_pkg::CFG_GAIN:       cfg_next.gain          = $signed(wr_data);
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= jabr_pkg::RST_THRESHOLD;
            cfg_reg.accel_rate    <= jabr_pkg::RST_ACCEL_RATE;
            cfg_reg.decel_rate    <= jabr_pkg::RST_DECEL_RATE;
            cfg_reg.limit         <= jabr_pkg::RST_LIMIT;
            cfg_reg.timeout_ticks <= jabr_pkg::RST_TIMEOUT;
            cfg_reg.gain          <= jabr_pkg::RST_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/jabr_mul.sv]
// Shared signed multiplier with registered operands and registered product.
module jabr_mul (
    input  logic                                  clk,
    input  jabr_pkg::mul_op_t                     op,
    output logic signed [jabr_pkg::PROD_W-1:0]    prod
);

    logic signed [jabr_pkg::MUL_W-1:0]  a_reg;
    logic signed [jabr_pkg::MUL_W-1:0]  b_reg;
    logic signed [jabr_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (op.load)
        begin
            a_reg <= op.a;
            b_reg <= op.b;
        end
        prod_reg <= a_reg * b_reg;
    end

    assign prod = prod_reg;

endmodule

[rtl/joystick_axis_boost_ramp.sv]
// Joystick axis conditioner: holds one axis sample, ramps a boost and scales the drive.
// Each item steps through the states in order: IDLE takes the item, PREP judges sample
// age and elapsed time, then two passes go through the single shared 18x18 multiplier
// (ramp step in RAMP, then output scale in DRIVE) with the boost update in BOOST between,
// and EMIT places the result in the output register. in_stall is low only in IDLE, the
// state that takes an item, and the last step waits for as long as a stalled earlier
// result still holds the output register. The output register lets a result wait while
// the next item is taken.
module joystick_axis_boost_ramp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic signed [15:0]                  axis_sample,
    input  logic [31:0]                         now,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [17:0]                  drive,
    output logic signed [15:0]                  boost,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jabr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jabr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    jabr_pkg::cfg_t    cfg;
    jabr_pkg::mul_op_t mul_op;
    logic signed [jabr_pkg::PROD_W-1:0] prod;

    jabr_pkg::state_t state_reg, state_next;

    logic signed [15:0] held_axis_reg;
    logic [31:0]        stamp_reg;
    logic               seen_reg;
    logic [31:0]        last_eval_reg;
    logic signed [15:0] boost_level_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] axis_eff_reg;
    jabr_pkg::ramp_t    ramp_reg;
    logic               dneg_reg;
    logic               out_valid_reg;
    logic signed [17:0] drive_reg;
    logic signed [15:0] boost_reg;

    logic               accept;
    logic               slot_free;
    logic [31:0]        age;
    logic               age_fresh;
    logic signed [15:0] axis_eff;
    logic signed [16:0] axis_ext;
    logic signed [16:0] thr_s;
    logic [31:0]        delta;
    logic [15:0]        dt;
    jabr_pkg::ramp_t    ramp_sel;
    logic signed [23:0] b_cur;
    logic signed [23:0] step;
    logic signed [23:0] b_ramp;
    logic signed [23:0] lim_s;
    logic signed [23:0] b_clamped;
    logic signed [15:0] b_new;
    logic signed [17:0] drive_sum;

    assign cfg_ready = 1'b1;

    jabr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    jabr_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // Sample age and elapsed time are read as signed wrapping differences.
    always_comb
    begin
        age       = now_reg - stamp_reg;
        age_fresh = age[31] || (age < {16'd0, cfg.timeout_ticks});
        axis_eff  = (seen_reg && age_fresh) ? held_axis_reg : 16'sd0;
        axis_ext  = 17'(axis_eff);
        thr_s     = $signed({2'b00, cfg.threshold});
        delta     = now_reg - last_eval_reg;
        dt        = (delta[31:16] != 16'd0) ? 16'hFFFF : delta[15:0];
        if (axis_ext >= thr_s)
            ramp_sel = jabr_pkg::RAMP_POS;
        else if (axis_ext <= -thr_s)
            ramp_sel = jabr_pkg::RAMP_NEG;
        else
            ramp_sel = jabr_pkg::RAMP_DECAY;
    end

    // Boost update from the ramp step held in the multiplier product.
    always_comb
    begin
        b_cur  = 24'(boost_level_reg);
        step   = $signed({2'b00, prod[31:10]});
        lim_s  = $signed({9'd0, cfg.limit});
        b_ramp = b_cur;
        if (!dneg_reg)
        begin
            case (ramp_reg)
                jabr_pkg::RAMP_POS:
                    b_ramp = (b_cur >= 24'sd0) ? b_cur + step : 24'sd0;
                jabr_pkg::RAMP_NEG:
                    b_ramp = (b_cur <= 24'sd0) ? b_cur - step : 24'sd0;
                default:
                begin
                    if (b_cur > 24'sd0)
                        b_ramp = (b_cur - step < 24'sd0) ? 24'sd0 : b_cur - step;
                    else if (b_cur < 24'sd0)
                        b_ramp = (b_cur + step > 24'sd0) ? 24'sd0 : b_cur + step;
                end
            endcase
        end
        if (b_ramp < -lim_s)
            b_clamped = -lim_s;
        else if (b_ramp > lim_s)
            b_clamped = lim_s;
        else
            b_clamped = b_ramp;
        b_new     = b_clamped[15:0];
        drive_sum = 18'(axis_eff_reg) + 18'(b_new);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jabr_pkg::ST_IDLE:  if (accept) state_next = jabr_pkg::ST_PREP;
            jabr_pkg::ST_PREP:  state_next = jabr_pkg::ST_RAMP;
            jabr_pkg::ST_RAMP:  state_next = jabr_pkg::ST_BOOST;
            jabr_pkg::ST_BOOST: state_next = jabr_pkg::ST_DRIVE;
            jabr_pkg::ST_DRIVE: state_next = jabr_pkg::ST_EMIT;
            jabr_pkg::ST_EMIT:  if (slot_free) state_next = jabr_pkg::ST_IDLE;
            default:            state_next = jabr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mul_op.load = 1'b0;
        mul_op.a    = 18'sd0;
        mul_op.b    = 18'sd0;
        case (state_reg)
            jabr_pkg::ST_IDLE:
                in_stall = 1'b0;
            jabr_pkg::ST_PREP:
            begin
                mul_op.load = 1'b1;
                mul_op.a    = (ramp_sel == jabr_pkg::RAMP_DECAY)
                              ? $signed({2'b00, cfg.decel_rate})
                              : $signed({2'b00, cfg.accel_rate});
                mul_op.b    = $signed({2'b00, dt});
            end
            jabr_pkg::ST_BOOST:
            begin
                mul_op.load = 1'b1;
                mul_op.a    = 18'(cfg.gain);
                mul_op.b    = drive_sum;
            end
            default:
                in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= jabr_pkg::ST_IDLE;
            held_axis_reg   <= 16'sd0;
            stamp_reg       <= 32'd0;
            seen_reg        <= 1'b0;
            last_eval_reg   <= 32'd0;
            boost_level_reg <= 16'sd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !opcode)
            begin
                held_axis_reg <= axis_sample;
                stamp_reg     <= now;
                seen_reg      <= 1'b1;
            end
            if (state_reg == jabr_pkg::ST_BOOST)
            begin
                boost_level_reg <= b_new;
                if (!dneg_reg)
                    last_eval_reg <= now_reg;
            end
            if (state_reg == jabr_pkg::ST_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            now_reg <= now;
        if (state_reg == jabr_pkg::ST_PREP)
        begin
            axis_eff_reg <= axis_eff;
            ramp_reg     <= ramp_sel;
            dneg_reg     <= delta[31];
        end
        if (state_reg == jabr_pkg::ST_EMIT && slot_free)
        begin
            // The product always fits 32 bits, so an arithmetic shift is a part-select.
            drive_reg <= prod[31:14];
            boost_reg <= boost_level_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign boost     = boost_reg;

`include "joystick_axis_boost_ramp_macros.svh"

    `JABR_ASSERT_NEXT(a_accept_prep, clk, rst_n, accept, state_reg == jabr_pkg::ST_PREP, "accepted item did not start")
    `JABR_ASSERT_NOW(a_boost_limit, clk, rst_n, state_reg == jabr_pkg::ST_DRIVE, (boost_level_reg <= $signed({1'b0, cfg.limit})) && (boost_level_reg >= -$signed({1'b0, cfg.limit})), "boost beyond limit")
    `JABR_ASSERT_NEXT(a_emit_valid, clk, rst_n, (state_reg == jabr_pkg::ST_EMIT) && slot_free, out_valid_reg && state_reg == jabr_pkg::ST_IDLE, "result not presented")
    `JABR_ASSERT_NEXT(a_neg_dt_keep, clk, rst_n, (state_reg == jabr_pkg::ST_BOOST) && dneg_reg, $stable(last_eval_reg), "evaluation time moved back")

endmodule

[dv/tb_joystick_axis_boost_ramp.sv]
// Self-checking testbench for joystick_axis_boost_ramp: directed and random items, scoreboard.
module tb_joystick_axis_boost_ramp;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_EVAL     = 1'b1;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   LONG_HOLD   = 300;
    localparam int   DRAIN       = 8;
    localparam int   PHASE_ITEMS = 264;

    typedef struct {
        logic signed [17:0] drive;
        logic signed [15:0] boost;
    } drive_boost_t;

    class ramp_scoreboard;
        logic [14:0]        threshold_r;
        logic [15:0]        accel_r;
        logic [15:0]        decel_r;
        logic [14:0]        limit_r;
        logic [15:0]        timeout_r;
        logic signed [15:0] gain_r;
        logic signed [15:0] held_axis;
        logic [31:0]        sample_stamp;
        logic               sample_seen;
        logic [31:0]        last_eval;
        logic signed [15:0] boost_level;
        drive_boost_t       drive_boost_q[$];
        int                 error_count;

        function new();
            threshold_r  = jabr_pkg::RST_THRESHOLD;
            accel_r      = jabr_pkg::RST_ACCEL_RATE;
            decel_r      = jabr_pkg::RST_DECEL_RATE;
            limit_r      = jabr_pkg::RST_LIMIT;
            timeout_r    = jabr_pkg::RST_TIMEOUT;
            gain_r       = jabr_pkg::RST_GAIN;
            held_axis    = '0;
            sample_stamp = '0;
            sample_seen  = 1'b0;
            last_eval    = '0;
            boost_level  = '0;
            error_count  = 0;
        endfunction

        function int outstanding();
            return drive_boost_q.size();
        endfunction

        function void set_register(logic [jabr_pkg::CFG_IDX_W-1:0] idx,
                                   logic [jabr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                jabr_pkg::CFG_THRESHOLD:  threshold_r = data[14:0];
                jabr_pkg::CFG_ACCEL_RATE: accel_r     = data;
                jabr_pkg::CFG_DECEL_RATE: decel_r     = data;
                jabr_pkg::CFG_LIMIT:      limit_r     = data[14:0];
                jabr_pkg::CFG_TIMEOUT:    timeout_r   = data;
                jabr_pkg::CFG_GAIN:       gain_r      = data;
                default: ;
            endcase
        endfunction

        // Works out the drive and boost that one accepted item must produce.
        function void take_item(logic op, logic signed [15:0] ax, logic [31:0] t);
            longint       axis_v;
            longint       b;
            longint       lim;
            longint       thr;
            longint       dt;
            longint       up;
            longint       down;
            longint       prod;
            logic [31:0]  age;
            logic [31:0]  elapsed;
            drive_boost_t result;
            if (op == OP_SAMPLE)
            begin
                held_axis    = ax;
                sample_stamp = t;
                sample_seen  = 1'b1;
            end
            axis_v = 0;
            b      = boost_level;
            lim    = limit_r;
            thr    = threshold_r;
            if (sample_seen)
            begin
                age = t - sample_stamp;
                // A sample stamped in the future is still fresh.
                if (age[31] || age < timeout_r)
                    axis_v = held_axis;
            end
            elapsed = t - last_eval;
            if (!elapsed[31])
            begin
                dt        = (elapsed > 32'hFFFF) ? 65535 : elapsed;
                up        = (accel_r * dt) >> 10;
                down      = (decel_r * dt) >> 10;
                last_eval = t;
                if (axis_v >= thr)
                    b = (b >= 0) ? b + up : 0;
                else if (axis_v <= -thr)
                    b = (b <= 0) ? b - up : 0;
                else if (b > 0)
                begin
                    b = b - down;
                    if (b < 0)
                        b = 0;
                end
                else if (b < 0)
                begin
                    b = b + down;
                    if (b > 0)
                        b = 0;
                end
            end
            if (b < -lim)
                b = -lim;
            if (b > lim)
                b = lim;
            boost_level  = b[15:0];
            prod         = gain_r * (axis_v + b);
            result.drive = prod >>> 14;
            result.boost = b[15:0];
            drive_boost_q.push_back(result);
        endfunction

        task report_mismatch(string what);
            error_count++;
            $display("MISMATCH: %s", what);
        endtask

        task take_result(logic signed [17:0] d, logic signed [15:0] b);
            drive_boost_t want;
            if (drive_boost_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result drive %0d boost %0d", d, b));
                return;
            end
            want = drive_boost_q.pop_front();
            if (d !== want.drive)
                report_mismatch($sformatf("drive %0d, expected %0d", d, want.drive));
            if (b !== want.boost)
                report_mismatch($sformatf("boost %0d, expected %0d", b, want.boost));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            opcode;
    logic signed [15:0]              axis_sample;
    logic [31:0]                     now;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [17:0]              drive;
    logic signed [15:0]              boost;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [jabr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [jabr_pkg::CFG_DATA_W-1:0] cfg_data;

    ramp_scoreboard sb;
    int             cycle_count;
    int             burst_left;
    int             run_sign = 1;
    bit             hold_req;
    logic [31:0]    clock_ms;
    jabr_pkg::cfg_t cfg_now;

    joystick_axis_boost_ramp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .axis_sample (axis_sample),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .boost       (boost),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** joystick_axis_boost_ramp: FAILED **");
            $finish;
        end
    end

    // Handshakes are sampled at the edge, before any new drive takes effect.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.take_item(opcode, axis_sample, now);
            if (out_valid && !out_stall)
                sb.take_result(drive, boost);
        end
    end

    // Receiver: segments of differing stall density, plus a long hold when asked.
    initial
    begin
        int seg;
        int pct;
        out_stall <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            seg = $urandom_range(10, 150);
            case ($urandom_range(3))
                0: pct = 0;
                1: pct = 30;
                2: pct = 60;
                default: pct = 90;
            endcase
            repeat (seg)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_req = 1'b0;
                end
                else
                    out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic send_item(logic op, logic signed [15:0] ax, logic [31:0] t);
        in_valid    <= 1'b1;
        opcode      <= op;
        axis_sample <= ax;
        now         <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    task automatic idle_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [jabr_pkg::CFG_IDX_W-1:0] idx,
                             logic [jabr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(jabr_pkg::cfg_t c);
        idle_wait();
        write_reg(jabr_pkg::CFG_THRESHOLD, {1'b0, c.threshold});
        write_reg(jabr_pkg::CFG_ACCEL_RATE, c.accel_rate);
        write_reg(jabr_pkg::CFG_DECEL_RATE, c.decel_rate);
        write_reg(jabr_pkg::CFG_LIMIT, {1'b0, c.limit});
        write_reg(jabr_pkg::CFG_TIMEOUT, c.timeout_ticks);
        write_reg(jabr_pkg::CFG_GAIN, c.gain);
        cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    function automatic jabr_pkg::cfg_t random_cfg();
        jabr_pkg::cfg_t c;
        c.threshold     = $urandom_range(0, 16384);
        c.accel_rate    = $urandom;
        c.decel_rate    = $urandom;
        c.limit         = $urandom_range(0, 16384);
        c.timeout_ticks = $urandom_range(1) ? $urandom_range(0, 2000) : $urandom;
        c.gain          = $urandom;
        return c;
    endfunction

    // Axis values mostly past the threshold with a sign that persists, so ramps build up.
    function automatic logic signed [15:0] pick_axis(int thr);
        int mag;
        if ($urandom_range(99) < 15)
            run_sign = -run_sign;
        case ($urandom_range(7))
            0: mag = 16384;
            1: mag = 0;
            2: mag = thr - 1 + $urandom_range(0, 2);
            3, 4, 5: mag = $urandom_range(thr, 16384);
            default: return $urandom_range(0, 32768) - 16384;
        endcase
        if (mag > 16384)
            mag = 16384;
        return mag * run_sign;
    endfunction

    task automatic random_phase(int count, bit with_hold);
        logic [31:0]        t;
        logic               op;
        logic signed [15:0] ax;
        int                 r;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 3)
                hold_req = 1'b1;
            if (i == 2 * count / 3)
                idle_wait();
            r = $urandom_range(99);
            if (r < 75)
            begin
                clock_ms = clock_ms + $urandom_range(0, 30);
                t = clock_ms;
            end
            else if (r < 83)
            begin
                clock_ms = clock_ms + $urandom_range(31, 1500);
                t = clock_ms;
            end
            else if (r < 88)
                t = clock_ms - $urandom_range(1, 3000);
            else if (r < 93)
            begin
                clock_ms = clock_ms + $urandom_range(65000, 300000);
                t = clock_ms;
            end
            else if (r < 96)
            begin
                clock_ms = $urandom;
                t = clock_ms;
            end
            else
                t = clock_ms + 32'h8000_0000 + $urandom_range(0, 1000);
            op = ($urandom_range(99) < 30) ? OP_SAMPLE : OP_EVAL;
            ax = pick_axis(cfg_now.threshold);
            send_item(op, ax, t);
        end
    endtask

    initial
    begin
        jabr_pkg::cfg_t c;
        sb          = new();
        burst_left  = 0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_EVAL;
        axis_sample <= '0;
        now         <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= jabr_pkg::CFG_THRESHOLD;
        cfg_data    <= '0;
        cfg_now     = '{jabr_pkg::RST_THRESHOLD, jabr_pkg::RST_ACCEL_RATE,
                        jabr_pkg::RST_DECEL_RATE, jabr_pkg::RST_LIMIT,
                        jabr_pkg::RST_TIMEOUT, jabr_pkg::RST_GAIN};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset settings (threshold 0.3, timeout 500 ms).
        send_item(OP_EVAL, 16'sd0, 32'd100);              // no sample stored yet
        send_item(OP_SAMPLE, 16'sd16384, 32'd200);        // full positive deflection
        send_item(OP_EVAL, 16'sd0, 32'd300);
        send_item(OP_EVAL, 16'sd0, 32'd699);              // one ms short of stale
        send_item(OP_EVAL, 16'sd0, 32'd700);              // exactly stale: decay
        send_item(OP_SAMPLE, 16'sd4915, 32'd800);         // exactly at threshold
        send_item(OP_SAMPLE, -16'sd16384, 32'd900);       // opposite side snaps boost
        send_item(OP_EVAL, 16'sd0, 32'd1300);
        send_item(OP_SAMPLE, 16'sd16384, 32'd1350);
        send_item(OP_SAMPLE, -16'sd4915, 32'd1400);       // exactly at minus threshold
        send_item(OP_SAMPLE, 16'sd4914, 32'd1500);        // just inside the band
        send_item(OP_SAMPLE, -16'sd4914, 32'd1600);
        send_item(OP_SAMPLE, 16'sd16384, 32'd1700);
        send_item(OP_EVAL, 16'sd0, 32'd1650);             // time runs backward
        send_item(OP_SAMPLE, 16'sd16384, 32'd201700);     // saturated step, clamp
        send_item(OP_SAMPLE, -16'sd16384, 32'd401700);
        send_item(OP_SAMPLE, -16'sd16384, 32'd601700);    // clamp at minus limit
        send_item(OP_SAMPLE, 16'sd0, 32'd601710);
        send_item(OP_EVAL, 16'sd0, 32'hFFFF_FFF0);
        send_item(OP_SAMPLE, 16'sd16384, 32'hFFFF_FFF8);
        send_item(OP_EVAL, 16'sd0, 32'h0000_0020);        // counter wraps

        clock_ms = 32'd700000;
        random_phase(PHASE_ITEMS, 1'b1);

        // Zero threshold, fastest rates, largest gain.
        program_regs('{15'd0, 16'hFFFF, 16'hFFFF, 15'd16384, 16'hFFFF, 16'sh7FFF});
        clock_ms = clock_ms + 32'd10;
        send_item(OP_SAMPLE, 16'sd0, clock_ms);           // zero axis ramps upward
        random_phase(PHASE_ITEMS, 1'b0);

        // Full threshold, frozen rates, no boost room, instant staleness, most negative gain.
        program_regs('{15'd16384, 16'd0, 16'd0, 15'd0, 16'd0, -16'sd32768});
        clock_ms = 32'hFFFF_0000;
        random_phase(PHASE_ITEMS, 1'b1);

        repeat (3)
        begin
            c = random_cfg();
            program_regs(c);
            random_phase(PHASE_ITEMS, 1'b0);
        end

        idle_wait();
        if (sb.error_count == 0)
            $display("** joystick_axis_boost_ramp: PASSED **");
        else
            $display("** joystick_axis_boost_ramp: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/jabr_pkg.sv
rtl/jabr_cfg.sv
rtl/jabr_mul.sv
rtl/joystick_axis_boost_ramp.sv
dv/tb_joystick_axis_boost_ramp.sv
